/* design/rc5_pkg.sv */
// Shared types, constants and rotate helpers for the RC5 block cipher.
package rc5_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned KEY_WORDS = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
    localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;
    localparam logic [4:0]        KEY_ROT = 5'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_LOAD,
        ST_MIX_A,
        ST_MIX_B,
        ST_ISSUE,
        ST_PRE,
        ST_ROUND,
        ST_POST,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic key_load;
        logic mix_a;
        logic mix_b;
        logic first_pass;
        logic enc_pre;
        logic round_enc;
        logic round_dec;
        logic dec_post;
        logic load_out;
    } t_dp_cmd;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] n);
        logic [2*WORD_W-1:0] t;
        t = {x, x} << n;
        return t[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                 input logic [4:0] n);
        logic [2*WORD_W-1:0] t;
        t = {x, x} >> n;
        return t[WORD_W-1:0];
    endfunction

endpackage

/* design/rc5_ram.sv */
// Generic RAM: one write port, two registered read ports.
module rc5_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 26
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr0,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr1,
    output logic [WIDTH-1:0]         o_rd_data0,
    output logic [WIDTH-1:0]         o_rd_data1
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd0;
    logic [WIDTH-1:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd0 <= r_mem[i_rd_addr0];
        r_rd1 <= r_mem[i_rd_addr1];
    end

    assign o_rd_data0 = r_rd0;
    assign o_rd_data1 = r_rd1;
endmodule

/* design/rc5_ctrl.sv */
// Controller: sequences key expansion, cipher rounds and the output handshake.
module rc5_ctrl #(
    parameter int unsigned ROUNDS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_op,
    output logic                             o_in_ready,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_key_wr,
    output rc5_pkg::t_dp_cmd                 o_cmd,
    output logic [$clog2(ROUNDS+1):0]        o_ti,
    output logic [1:0]                       o_li,
    output logic [$clog2(ROUNDS+1):0]        o_rd_addr0,
    output logic [$clog2(ROUNDS+1):0]        o_rd_addr1
);
    import rc5_pkg::*;

    localparam int unsigned PW    = $clog2(ROUNDS + 1);
    localparam int unsigned AW    = PW + 1;
    localparam int unsigned TW    = 2 * (ROUNDS + 1);
    localparam int unsigned STEPS = 3 * TW;
    localparam int unsigned SW    = $clog2(STEPS);

    t_state          r_state, n_state;
    logic            r_op, n_op;
    logic            r_sched_ok, n_sched_ok;
    logic            r_out_valid, n_out_valid;
    logic [AW-1:0]   r_ti, n_ti;
    logic [1:0]      r_li, n_li;
    logic [SW-1:0]   r_step, n_step;
    logic [PW-1:0]   r_round, n_round;
    logic [PW-1:0]   w_pair;
    logic [AW-1:0]   w_ti_nx;
    logic            w_use_ti;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_ENCRYPT;
            r_sched_ok  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ti        <= '0;
            r_li        <= '0;
            r_step      <= '0;
            r_round     <= '0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_sched_ok  <= n_sched_ok;
            r_out_valid <= n_out_valid;
            r_ti        <= n_ti;
            r_li        <= n_li;
            r_step      <= n_step;
            r_round     <= n_round;
        end
    end

    assign w_ti_nx = (r_ti == AW'(TW - 1)) ? '0 : r_ti + AW'(1);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_sched_ok  = r_sched_ok;
        n_ti        = r_ti;
        n_li        = r_li;
        n_step      = r_step;
        n_round     = r_round;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        w_pair      = '0;
        w_use_ti    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_op          = i_in_op;
                    n_state       = r_sched_ok ? ST_ISSUE : ST_KEY_LOAD;
                end
            end
            ST_KEY_LOAD: begin
                o_cmd.key_load = 1'b1;
                n_ti           = '0;
                n_li           = '0;
                n_step         = '0;
                n_state        = ST_MIX_A;
            end
            ST_MIX_A: begin
                o_cmd.mix_a      = 1'b1;
                o_cmd.first_pass = (r_step < SW'(TW));
                n_state          = ST_MIX_B;
            end
            ST_MIX_B: begin
                // fetch the next table word for the following step
                o_cmd.mix_b = 1'b1;
                w_use_ti    = 1'b1;
                n_ti        = w_ti_nx;
                n_li        = r_li + 2'd1;
                n_step      = r_step + SW'(1);
                if (r_step == SW'(STEPS - 1)) begin
                    n_sched_ok = 1'b1;
                    n_state    = ST_ISSUE;
                end else begin
                    n_state = ST_MIX_A;
                end
            end
            ST_ISSUE: begin
                if (r_op == OP_ENCRYPT) begin
                    w_pair  = '0;
                    n_round = PW'(1);
                    n_state = ST_PRE;
                end else begin
                    w_pair  = PW'(ROUNDS);
                    n_round = PW'(ROUNDS);
                    n_state = ST_ROUND;
                end
            end
            ST_PRE: begin
                o_cmd.enc_pre = 1'b1;
                w_pair        = r_round;
                n_state       = ST_ROUND;
            end
            ST_ROUND: begin
                if (r_op == OP_ENCRYPT) begin
                    o_cmd.round_enc = 1'b1;
                    w_pair          = r_round + PW'(1);
                    n_round         = r_round + PW'(1);
                    if (r_round == PW'(ROUNDS)) begin
                        n_state = ST_OUT;
                    end
                end else begin
                    o_cmd.round_dec = 1'b1;
                    w_pair          = r_round - PW'(1);
                    n_round         = r_round - PW'(1);
                    if (r_round == PW'(1)) begin
                        n_state = ST_POST;
                    end
                end
            end
            ST_POST: begin
                o_cmd.dec_post = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                // hold the finished block until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        if (i_key_wr) begin
            n_sched_ok = 1'b0;
        end
    end

    assign o_rd_addr0  = w_use_ti ? w_ti_nx : {w_pair, 1'b0};
    assign o_rd_addr1  = {w_pair, 1'b1};
    assign o_ti        = r_ti;
    assign o_li        = r_li;
    assign o_out_valid = r_out_valid;
endmodule

/* design/rc5_dp.sv */
// Datapath: key registers, key table, key mixing and one cipher round per cycle.
module rc5_dp #(
    parameter int unsigned ROUNDS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rc5_pkg::t_dp_cmd                     i_cmd,
    input  logic [$clog2(ROUNDS+1):0]            i_ti,
    input  logic [1:0]                           i_li,
    input  logic [$clog2(ROUNDS+1):0]            i_rd_addr0,
    input  logic [$clog2(ROUNDS+1):0]            i_rd_addr1,
    input  logic                                 i_cfg_wr,
    input  logic [rc5_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [2*rc5_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic [rc5_pkg::WORD_W-1:0]           i_word_a,
    input  logic [rc5_pkg::WORD_W-1:0]           i_word_b,
    output logic [rc5_pkg::WORD_W-1:0]           o_result_a,
    output logic [rc5_pkg::WORD_W-1:0]           o_result_b
);
    import rc5_pkg::*;

    localparam int unsigned TW = 2 * (ROUNDS + 1);

    logic [2*WORD_W-1:0] r_key_low;
    logic [2*WORD_W-1:0] r_key_high;
    logic [WORD_W-1:0]   r_lw [KEY_WORDS];
    logic [WORD_W-1:0]   r_ka;
    logic [WORD_W-1:0]   r_kb;
    logic [WORD_W-1:0]   r_magic;
    logic [WORD_W-1:0]   r_ca;
    logic [WORD_W-1:0]   r_cb;
    logic [WORD_W-1:0]   r_res_a;
    logic [WORD_W-1:0]   r_res_b;

    logic [WORD_W-1:0]   w_rd0;
    logic [WORD_W-1:0]   w_rd1;
    logic [WORD_W-1:0]   w_mix_src;
    logic [WORD_W-1:0]   w_mix_a;
    logic [WORD_W-1:0]   w_ab_sum;
    logic [WORD_W-1:0]   w_mix_b;
    logic [WORD_W-1:0]   w_enc_a;
    logic [WORD_W-1:0]   w_enc_b;
    logic [WORD_W-1:0]   w_dec_a;
    logic [WORD_W-1:0]   w_dec_b;

    rc5_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (i_cmd.mix_a),
        .i_wr_addr  (i_ti),
        .i_wr_data  (w_mix_a),
        .i_rd_addr0 (i_rd_addr0),
        .i_rd_addr1 (i_rd_addr1),
        .o_rd_data0 (w_rd0),
        .o_rd_data1 (w_rd1)
    );

    // first pass takes the table word straight from the P/Q sequence
    assign w_mix_src = i_cmd.first_pass ? r_magic : w_rd0;
    assign w_mix_a   = rotl32(w_mix_src + r_ka + r_kb, KEY_ROT);
    assign w_ab_sum  = r_ka + r_kb;
    assign w_mix_b   = rotl32(r_lw[i_li] + w_ab_sum, w_ab_sum[4:0]);

    assign w_enc_a = rotl32(r_ca ^ r_cb, r_cb[4:0]) + w_rd0;
    assign w_enc_b = rotl32(r_cb ^ w_enc_a, w_enc_a[4:0]) + w_rd1;
    assign w_dec_b = rotr32(r_cb - w_rd1, r_ca[4:0]) ^ r_ca;
    assign w_dec_a = rotr32(r_ca - w_rd0, w_dec_b[4:0]) ^ w_dec_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_wr) begin
            if (i_cfg_index == CFG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
            if (i_cfg_index == CFG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_lw[0] <= r_key_low[WORD_W-1:0];
            r_lw[1] <= r_key_low[2*WORD_W-1:WORD_W];
            r_lw[2] <= r_key_high[WORD_W-1:0];
            r_lw[3] <= r_key_high[2*WORD_W-1:WORD_W];
            r_ka    <= '0;
            r_kb    <= '0;
            r_magic <= MAGIC_P;
        end
        if (i_cmd.mix_a) begin
            r_ka    <= w_mix_a;
            r_magic <= r_magic + MAGIC_Q;
        end
        if (i_cmd.mix_b) begin
            r_lw[i_li] <= w_mix_b;
            r_kb       <= w_mix_b;
        end

        if (i_cmd.load_in) begin
            r_ca <= i_word_a;
            r_cb <= i_word_b;
        end
        if (i_cmd.enc_pre) begin
            r_ca <= r_ca + w_rd0;
            r_cb <= r_cb + w_rd1;
        end
        if (i_cmd.round_enc) begin
            r_ca <= w_enc_a;
            r_cb <= w_enc_b;
        end
        if (i_cmd.round_dec) begin
            r_ca <= w_dec_a;
            r_cb <= w_dec_b;
        end
        if (i_cmd.dec_post) begin
            r_ca <= r_ca - w_rd0;
            r_cb <= r_cb - w_rd1;
        end
        if (i_cmd.load_out) begin
            r_res_a <= r_ca;
            r_res_b <= r_cb;
        end
    end

    assign o_result_a = r_res_a;
    assign o_result_b = r_res_b;
endmodule

/* design/rc5_block_cipher_top.sv */
// Top level of the RC5-32 block cipher with a 128-bit key.
//
//  channel   direction  handshake                 payload
//  s         in         i_s_tvalid / o_s_tready   tdata word_a, word_b; tuser op
//  m         out        o_m_tvalid / i_m_tready   tdata result_a, result_b
//  cfg       in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One block at a time, one round per cycle through the two read ports of the round-key
// table. Encrypt runs ISSUE, PRE, the rounds, OUT; decrypt runs ISSUE, the rounds, POST,
// OUT. After reset or a key write, the first block first runs the key expansion, each
// mixing step taking state MIX_A and then MIX_B.
// A stalled result waits in the output register; the next block is accepted meanwhile.
// Reset is synchronous, active low; the key resets to zero.
module rc5_block_cipher_top #(
    parameter int unsigned ROUNDS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [63:0]                        i_s_tdata,   // word_a, word_b
    input  logic                               i_s_tuser,   // op
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [63:0]                        o_m_tdata,   // result_a, result_b
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rc5_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [63:0]                        i_cfg_data
);
    import rc5_pkg::*;

    localparam int unsigned AW = $clog2(ROUNDS + 1) + 1;

    t_dp_cmd          w_cmd;
    logic [AW-1:0]    w_ti;
    logic [1:0]       w_li;
    logic [AW-1:0]    w_rd_addr0;
    logic [AW-1:0]    w_rd_addr1;
    logic             w_cfg_wr;
    logic             w_key_wr;
    logic [WORD_W-1:0] w_result_a;
    logic [WORD_W-1:0] w_result_b;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;
    // drop writes beyond the register list
    assign w_key_wr    = w_cfg_wr &&
                         (i_cfg_index == CFG_KEY_LOW || i_cfg_index == CFG_KEY_HIGH);

    rc5_ctrl #(
        .ROUNDS (ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_in_op     (i_s_tuser),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_key_wr    (w_key_wr),
        .o_cmd       (w_cmd),
        .o_ti        (w_ti),
        .o_li        (w_li),
        .o_rd_addr0  (w_rd_addr0),
        .o_rd_addr1  (w_rd_addr1)
    );

    rc5_dp #(
        .ROUNDS (ROUNDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_ti        (w_ti),
        .i_li        (w_li),
        .i_rd_addr0  (w_rd_addr0),
        .i_rd_addr1  (w_rd_addr1),
        .i_cfg_wr    (w_key_wr),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_word_a    (i_s_tdata[31:0]),
        .i_word_b    (i_s_tdata[63:32]),
        .o_result_a  (w_result_a),
        .o_result_b  (w_result_b)
    );

    assign o_m_tdata = {w_result_b, w_result_a};
endmodule

/* design/rc5_checker.sv */
// Port-level checker for the RC5 block cipher top level, with its bind.
module rc5_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

    // one block in flight: no second transaction right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while a block is in progress");

    // no result can appear the cycle after an input transaction
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !$rose(o_m_tvalid))
        else $error("result appeared too early");

    // reset leaves the block empty and ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("block not idle after reset");
endmodule

bind rc5_block_cipher_top rc5_checker u_rc5_checker (.*);

/* test/tb_top.sv */
// Testbench for the RC5-32/12/16 cipher: directed rows, then random keys and blocks.
`timescale 1ns / 1ps

module tb_top;
    import rc5_pkg::*;

    localparam int ROUNDS_N    = 12;
    localparam int TABLE_N     = 2 * (ROUNDS_N + 1);
    localparam int MIX_STEPS   = 3 * TABLE_N;
    localparam int ITEM_TARGET = 1000;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYC  = 4;
    localparam int TAIL_CYC    = 40;
    localparam int SCRIPT_LEN  = 22;

    // register indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic {ROW_BLOCK, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic                 op;
        logic [31:0]          a;
        logic [31:0]          b;
        logic [CFG_IDX_W-1:0] idx;
        logic [63:0]          val;
    } t_drive_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [63:0]          i_s_tdata   = '0;   // word_a, word_b
    logic                 i_s_tuser   = 1'b0; // op
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [63:0]          o_m_tdata;          // result_a, result_b
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data  = '0;

    rc5_block_cipher_top #(
        .ROUNDS(ROUNDS_N)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // cipher state as the predictor sees it
    logic [63:0] key_lo_q    = '0;
    logic [63:0] key_hi_q    = '0;
    logic [31:0] sched [TABLE_N];
    bit          sched_fresh = 1'b0;

    logic [63:0] expected_blocks [$];
    int          fail_count  = 0;
    int          quiet_cycles = 0;
    int          stall_left  = 0;
    bit          calm        = 1'b0;
    logic [63:0] want_block;
    t_drive_row  script [SCRIPT_LEN];

    function automatic logic [31:0] rot_left(input logic [31:0] x, input logic [31:0] n);
        int unsigned s;
        s = n % 32;
        if (s == 0) return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] rot_right(input logic [31:0] x, input logic [31:0] n);
        int unsigned s;
        s = n % 32;
        if (s == 0) return x;
        return (x >> s) | (x << (32 - s));
    endfunction

    function automatic void expand_schedule();
        logic [31:0] lw [KEY_WORDS];
        logic [31:0] sa;
        logic [31:0] sb;
        int          ti;
        int          li;
        lw[0] = key_lo_q[31:0];
        lw[1] = key_lo_q[63:32];
        lw[2] = key_hi_q[31:0];
        lw[3] = key_hi_q[63:32];
        sa = '0;
        sb = '0;
        ti = 0;
        li = 0;
        sched[0] = MAGIC_P;
        for (int k = 1; k < TABLE_N; k++) sched[k] = sched[k-1] + MAGIC_Q;
        for (int k = 0; k < MIX_STEPS; k++) begin
            sched[ti] = rot_left(sched[ti] + sa + sb, 32'(KEY_ROT));
            sa = sched[ti];
            lw[li] = rot_left(lw[li] + sa + sb, sa + sb);
            sb = lw[li];
            ti = (ti + 1) % TABLE_N;
            li = (li + 1) % KEY_WORDS;
        end
        sched_fresh = 1'b1;
    endfunction

    // returns {result_b, result_a}
    function automatic logic [63:0] cipher_block(input logic op, input logic [31:0] a_in,
                                                 input logic [31:0] b_in);
        logic [31:0] a;
        logic [31:0] b;
        if (!sched_fresh) expand_schedule();
        a = a_in;
        b = b_in;
        if (op == OP_ENCRYPT) begin
            a += sched[0];
            b += sched[1];
            for (int r = 1; r <= ROUNDS_N; r++) begin
                a = rot_left(a ^ b, b) + sched[2*r];
                b = rot_left(b ^ a, a) + sched[2*r+1];
            end
        end else begin
            for (int r = ROUNDS_N; r > 0; r--) begin
                b = rot_right(b - sched[2*r+1], a) ^ a;
                a = rot_right(a - sched[2*r], b) ^ b;
            end
            b -= sched[1];
            a -= sched[0];
        end
        return {b, a};
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 94) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 99) < 45) return 0;
        return gap_len();
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return {27'($urandom_range(0, 32'h07ff_ffff)), 5'd0};
            4: return {27'($urandom_range(0, 32'h07ff_ffff)), 5'd31};
            default: return $urandom;
        endcase
    endfunction

    task automatic push_block(input logic op, input logic [31:0] a, input logic [31:0] b);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, a};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        expected_blocks.push_back(cipher_block(op, a, b));
    endtask

    // drop valid and wait until every pending result is out
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        drain();
        repeat ($urandom_range(0, 3)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_LOW: begin
                key_lo_q    = val;
                sched_fresh = 1'b0;
            end
            CFG_KEY_HIGH: begin
                key_hi_q    = val;
                sched_fresh = 1'b0;
            end
            default: ;
        endcase
    endtask

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < 30) begin
            i_m_tready <= 1'b0;
            stall_left = gap_len() - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_blocks.size() == 0) begin
                $display("%0t: result with no block pending: a=%h b=%h",
                         $time, o_m_tdata[31:0], o_m_tdata[63:32]);
                fail_count++;
            end else begin
                want_block = expected_blocks.pop_front();
                if (o_m_tdata[31:0] !== want_block[31:0]) begin
                    $display("%0t: result_a expected %h actual %h",
                             $time, want_block[31:0], o_m_tdata[31:0]);
                    fail_count++;
                end
                if (o_m_tdata[63:32] !== want_block[63:32]) begin
                    $display("%0t: result_b expected %h actual %h",
                             $time, want_block[63:32], o_m_tdata[63:32]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int          n_items;
        int          batch;
        logic [31:0] a;
        logic [31:0] b;
        logic [63:0] ct;
        logic        op;

        script = '{
            // reset key: first block runs the key expansion
            '{ROW_BLOCK, OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, CFG_KEY_LOW, 64'h0},
            '{ROW_BLOCK, OP_DECRYPT, 32'h0000_0000, 32'h0000_0000, CFG_KEY_LOW, 64'h0},
            '{ROW_BLOCK, OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff, CFG_KEY_LOW, 64'h0},
            '{ROW_BLOCK, OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff, CFG_KEY_LOW, 64'h0},
            '{ROW_BLOCK, OP_ENCRYPT, 32'h0000_0001, 32'h8000_0000, CFG_KEY_LOW, 64'h0},
            '{ROW_BLOCK, OP_DECRYPT, 32'h8000_0000, 32'h0000_0001, CFG_KEY_LOW, 64'h0},
            '{ROW_REG,   OP_ENCRYPT, 32'h0, 32'h0, CFG_KEY_LOW,  64'hffff_ffff_ffff_ffff},
            '{ROW_REG,   OP_ENCRYPT, 32'h0, 32'h0, CFG_KEY_HIGH, 64'hffff_ffff_ffff_ffff},
            '{ROW_BLOCK, OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, CFG_KEY_LOW, 64'h0},
            // rotation amounts of 31 and of 32 (which wraps to none)
            '{ROW_BLOCK, OP_ENCRYPT, 32'h0000_001f, 32'h0000_0020, CFG_KEY_LOW, 64'h0},
            '{ROW_BLOCK, OP_DECRYPT, 32'h0000_001f, 32'h0000_0020, CFG_KEY_LOW, 64'h0},
            // unused register indexes leave the key alone
            '{ROW_REG,   OP_ENCRYPT, 32'h0, 32'h0, CFG_SPARE_2, 64'h0123_4567_89ab_cdef},
            '{ROW_REG,   OP_ENCRYPT, 32'h0, 32'h0, CFG_SPARE_3, 64'hfedc_ba98_7654_3210},
            '{ROW_BLOCK, OP_ENCRYPT, 32'h1234_5678, 32'h9abc_def0, CFG_KEY_LOW, 64'h0},
            '{ROW_REG,   OP_ENCRYPT, 32'h0, 32'h0, CFG_KEY_LOW,  64'h0706_0504_0302_0100},
            '{ROW_REG,   OP_ENCRYPT, 32'h0, 32'h0, CFG_KEY_HIGH, 64'h0f0e_0d0c_0b0a_0908},
            '{ROW_BLOCK, OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000, CFG_KEY_LOW, 64'h0},
            '{ROW_BLOCK, OP_DECRYPT, 32'hdead_beef, 32'h0bad_f00d, CFG_KEY_LOW, 64'h0},
            '{ROW_REG,   OP_ENCRYPT, 32'h0, 32'h0, CFG_KEY_LOW,  64'h0},
            '{ROW_BLOCK, OP_ENCRYPT, 32'ha5a5_a5a5, 32'h5a5a_5a5a, CFG_KEY_LOW, 64'h0},
            '{ROW_REG,   OP_ENCRYPT, 32'h0, 32'h0, CFG_KEY_HIGH, 64'h0},
            '{ROW_BLOCK, OP_DECRYPT, 32'h0000_0000, 32'h0000_0000, CFG_KEY_LOW, 64'h0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++) begin
            if (script[i].kind == ROW_REG) begin
                write_reg(script[i].idx, script[i].val);
            end else begin
                push_block(script[i].op, script[i].a, script[i].b);
            end
        end

        n_items = 0;
        while (n_items < ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0: begin
                    write_reg(CFG_KEY_LOW, 64'h0);
                    write_reg(CFG_KEY_HIGH, 64'h0);
                end
                1: begin
                    write_reg(CFG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
                    write_reg(CFG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
                end
                2: write_reg(CFG_KEY_LOW, {$urandom, $urandom});
                3: write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
                4: write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                             {$urandom, $urandom});
                5: ;
                default: begin
                    write_reg(CFG_KEY_LOW, {pick_word(), pick_word()});
                    write_reg(CFG_KEY_HIGH, {pick_word(), pick_word()});
                end
            endcase
            calm  = ($urandom_range(0, 4) == 0);
            batch = $urandom_range(10, 70);
            for (int j = 0; j < batch; j++) begin
                a = pick_word();
                b = pick_word();
                if ($urandom_range(0, 99) < 35) begin
                    // encrypt, then decrypt the ciphertext back
                    ct = cipher_block(OP_ENCRYPT, a, b);
                    push_block(OP_ENCRYPT, a, b);
                    push_block(OP_DECRYPT, ct[31:0], ct[63:32]);
                    n_items += 2;
                end else begin
                    op = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
                    push_block(op, a, b);
                    n_items++;
                end
            end
        end

        calm = 1'b0;
        drain();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (fail_count == 0 && expected_blocks.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
design/rc5_pkg.sv
design/rc5_ram.sv
design/rc5_ctrl.sv
design/rc5_dp.sv
design/rc5_block_cipher_top.sv
design/rc5_checker.sv
test/tb_top.sv
